/* rtl/teq_pkg.sv */
package teq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int TIME_W      = 31;
  localparam int RESULT_CAP  = 16;
  localparam int NRES_W      = $clog2(RESULT_CAP + 1);

  localparam logic [TIME_W:0] CYCLE_LIMIT = 32'd1073741824;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DEACT  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FIRED   = 2'd1,
    KIND_NO_SLOT = 2'd2,
    KIND_LIMIT   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_QUANTUM  = 3'd1,
    EV_AGE      = 3'd2,
    EV_END_WAIT = 3'd3,
    EV_ILLEGAL  = 3'd4
  } ev_t;

  localparam logic [2:0] ACT_NULL = 3'd0;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] slot;
    logic [7:0] pid;
    ev_t        code;
  } res_t;

  function automatic ev_t ev_of_act(input logic [2:0] act);
    ev_t ev;
    case (act)
      3'd0:    ev = EV_NONE;
      3'd1:    ev = EV_QUANTUM;
      3'd2:    ev = EV_AGE;
      3'd3:    ev = EV_END_WAIT;
      default: ev = EV_ILLEGAL;
    endcase
    return ev;
  endfunction

endpackage

/* rtl/timer_event_queue.sv */
// timer event queue
// input channel: in_valid/in_stall carry one word (operation, delay, owner_pid,
//   action_code, period, handle); a word is taken when in_valid is high and
//   in_stall is low. in_stall stays high while a word is being worked on.
// output channel: out_valid/out_stall; each word carries a result and out_last
//   marks the final result of one input word. add answers with one word,
//   tick with zero to sixteen words, deactivate with none.
// steps: a word is taken in idle, and deactivate is done then. a placed add walks
//   past list places in scan, then answers from flush. tick checks the list head;
//   each fired entry goes to renew, where a recurring entry gets its new
//   expiry and is walked back into the list in scan, and tick finishes in
//   flush. one shared adder and one expiry comparator are stepped by the
//   sequencer through these states.
// the results wait in a holding register and an output register, so a stall
//   at the receiver only holds the sequencer when both are full.
// reset: synchronous active-low; counter, slot busy bits and list length are
//   cleared, block comes out idle with no result pending.
module timer_event_queue
  import teq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [TIME_W-1:0] in_delay,
  input  logic [7:0]        in_owner_pid,
  input  logic [2:0]        in_action_code,
  input  logic [TIME_W-1:0] in_period,
  input  logic [3:0]        in_handle,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic [3:0]        out_slot,
  output logic [7:0]        out_event_pid,
  output logic [2:0]        out_event_code,
  output logic [TIME_W-1:0] out_now_time,
  output logic              out_last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_RENEW = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r;

  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] slot_expiry_r [TIMER_SLOTS];
  logic [7:0]        slot_owner_r  [TIMER_SLOTS];
  logic [2:0]        slot_act_r    [TIMER_SLOTS];
  logic [TIME_W-1:0] slot_period_r [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] slot_busy_r;
  logic [SLOT_W-1:0] due_r [TIMER_SLOTS];
  logic [CNT_W-1:0]  queued_r;

  logic [CNT_W-1:0]  pos_r;
  logic [SLOT_W-1:0] cur_r;
  logic [TIME_W-1:0] key_r;
  logic              mode_add_r;
  logic [NRES_W-1:0] nres_r;
  logic              pend_v_r;
  res_t              pend_r;
  logic              out_valid_r;
  res_t              out_r;
  logic [TIME_W-1:0] out_now_r;
  logic              out_last_r;

  // shared adder and comparator
  logic [TIME_W-1:0] add_b;
  logic [TIME_W:0]   add_sum;
  logic              add_over;
  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  logic              cmp_le;

  logic              in_take;
  logic              emit_ok;
  logic              out_load;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] scan_slot;
  logic              fire;
  logic              scan_more;
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] deact_idx;
  logic              deact_ok;
  logic              renew_ok;
  ev_t               head_ev;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign head      = due_r[0];
  assign scan_slot = due_r[pos_r[SLOT_W-1:0]];
  assign head_ev   = ev_of_act(slot_act_r[head]);

  always_comb begin
    if (state_r == S_IDLE) begin
      add_b = (in_operation == OP_TICK) ? TIME_W'(1) : in_delay;
    end else begin
      add_b = slot_period_r[cur_r];
    end
    add_sum  = {1'b0, now_r} + {1'b0, add_b};
    add_over = (add_sum > CYCLE_LIMIT);
  end

  always_comb begin
    if (state_r == S_SCAN) begin
      cmp_a = slot_expiry_r[scan_slot];
      cmp_b = key_r;
    end else begin
      cmp_a = slot_expiry_r[head];
      cmp_b = now_r;
    end
    cmp_le = (cmp_a <= cmp_b);
  end

  assign fire      = (queued_r != '0) && (nres_r < NRES_W'(RESULT_CAP)) && cmp_le;
  assign scan_more = (pos_r < queued_r) && cmp_le;
  assign renew_ok  = (slot_period_r[cur_r] != '0) && !add_over;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy_r[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign deact_idx = SLOT_W'(in_handle);
  assign deact_ok  = (32'(in_handle) < TIMER_SLOTS) && slot_busy_r[deact_idx];

  assign out_load = pend_v_r && emit_ok &&
                    ((state_r == S_FLUSH) || ((state_r == S_CHECK) && fire));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      slot_busy_r <= '0;
      queued_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      nres_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_r       <= pend_r;
        out_now_r   <= now_r;
        out_last_r  <= (state_r == S_FLUSH);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            case (in_operation)
              OP_TICK: begin
                mode_add_r <= 1'b0;
                if (add_over) begin
                  now_r    <= CYCLE_LIMIT[TIME_W-1:0];
                  pend_r   <= '{kind: KIND_LIMIT, slot: '0, pid: '0, code: EV_NONE};
                  pend_v_r <= 1'b1;
                  nres_r   <= NRES_W'(1);
                end else begin
                  now_r  <= add_sum[TIME_W-1:0];
                  nres_r <= '0;
                end
                state_r <= S_CHECK;
              end
              OP_ADD: begin
                mode_add_r <= 1'b1;
                if (add_over) begin
                  pend_r   <= '{kind: KIND_LIMIT, slot: '0, pid: '0, code: EV_NONE};
                  pend_v_r <= 1'b1;
                  state_r  <= S_FLUSH;
                end else if (!free_any) begin
                  pend_r   <= '{kind: KIND_NO_SLOT, slot: '0, pid: '0, code: EV_NONE};
                  pend_v_r <= 1'b1;
                  state_r  <= S_FLUSH;
                end else begin
                  slot_busy_r[free_slot]   <= 1'b1;
                  slot_expiry_r[free_slot] <= add_sum[TIME_W-1:0];
                  slot_owner_r[free_slot]  <= in_owner_pid;
                  slot_act_r[free_slot]    <= in_action_code;
                  slot_period_r[free_slot] <= in_period;
                  cur_r   <= free_slot;
                  key_r   <= add_sum[TIME_W-1:0];
                  pos_r   <= '0;
                  state_r <= S_SCAN;
                end
              end
              OP_DEACT: begin
                if (deact_ok) begin
                  slot_act_r[deact_idx] <= ACT_NULL;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_CHECK: begin
          if (!fire) begin
            state_r <= S_FLUSH;
          end else if (!pend_v_r || emit_ok) begin
            pend_r <= '{kind: KIND_FIRED, slot: 4'(head),
                        pid: (head_ev == EV_END_WAIT) ? slot_owner_r[head] : 8'd0,
                        code: head_ev};
            pend_v_r <= 1'b1;
            nres_r   <= nres_r + NRES_W'(1);
            for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
              due_r[i] <= due_r[i+1];
            end
            queued_r <= queued_r - CNT_W'(1);
            cur_r    <= head;
            state_r  <= S_RENEW;
          end
        end

        S_RENEW: begin
          if (renew_ok) begin
            slot_expiry_r[cur_r] <= add_sum[TIME_W-1:0];
            key_r   <= add_sum[TIME_W-1:0];
            pos_r   <= '0;
            state_r <= S_SCAN;
          end else begin
            slot_busy_r[cur_r] <= 1'b0;
            state_r <= S_CHECK;
          end
        end

        S_SCAN: begin
          if (scan_more) begin
            pos_r <= pos_r + CNT_W'(1);
          end else begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
              if (CNT_W'(i) == pos_r) begin
                due_r[i] <= cur_r;
              end else if ((CNT_W'(i) > pos_r) && (i > 0)) begin
                due_r[i] <= due_r[(i > 0) ? i - 1 : 0];
              end
            end
            queued_r <= queued_r + CNT_W'(1);
            if (mode_add_r) begin
              pend_r   <= '{kind: KIND_ADDED, slot: 4'(cur_r), pid: '0, code: EV_NONE};
              pend_v_r <= 1'b1;
              state_r  <= S_FLUSH;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end

        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (emit_ok) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_r.kind;
  assign out_slot        = out_r.slot;
  assign out_event_pid   = out_r.pid;
  assign out_event_code  = out_r.code;
  assign out_now_time    = out_now_r;
  assign out_last        = out_last_r;

endmodule

/* rtl/teq_checker.sv */
module teq_checker
  import teq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_result_kind,
  input logic [3:0]        out_slot,
  input logic [7:0]        out_event_pid,
  input logic [2:0]        out_event_code,
  input logic [TIME_W-1:0] out_now_time,
  input logic              out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_slot) && $stable(out_now_time) && $stable(out_last))
    else $error("stalled output word changed");

  // add answers are single words
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ADDED || out_result_kind == KIND_NO_SLOT)
      |-> out_last)
    else $error("add answer not marked last");

  // only fired words carry an event
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != KIND_FIRED) |-> out_event_code == EV_NONE)
    else $error("event code on a non-fired word");

  // pid only on end-wait events
  a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code != EV_END_WAIT) |-> out_event_pid == 8'd0)
    else $error("pid on a word that is not end-wait");

  // counter never passes the limit
  a_time_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_now_time} <= CYCLE_LIMIT)
    else $error("time beyond cycle limit");

endmodule

bind timer_event_queue teq_checker u_teq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_slot        (out_slot),
  .out_event_pid   (out_event_pid),
  .out_event_code  (out_event_code),
  .out_now_time    (out_now_time),
  .out_last        (out_last)
);
